/* rtl/core/orb_pkg.sv */
package orb_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  localparam int OP_W  = 2;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam int CAP_RESET = 16;
  localparam int CAP_LIMIT = 31;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

/* rtl/core/overwriting_ring_buffer_top.sv */
// Overwriting ring buffer of up to min(DEPTH, 31) words of WIDTH bits. A
// request (append, read at index, write at index, clear) is taken on any
// cycle with start high; busy stays low, so one request per cycle is
// sustained. Each request gives exactly one result on the out_ ports in the
// next cycle, marked by out_strobe for that single cycle; the receiver
// cannot stall, so results must be captured when they appear. The result is
// registered: the slot store has a registered read port, which is read and
// written at the same edge as head and fill are updated. Writing cfg_capacity
// empties the buffer and must happen only while no result is pending.
module overwriting_ring_buffer_top
  import orb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [WIDTH-1:0]  in_data,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_capacity,
  output logic              out_strobe,
  output logic [WIDTH-1:0]  out_read_data,
  output logic              out_read_valid,
  output logic [WIDTH-1:0]  out_evicted_data,
  output logic              out_evicted_valid,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_is_empty,
  output logic              out_index_error
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_MAX = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
  localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  cnt_t cap_r, cap_nxt;
  cnt_t head_r, head_nxt;
  cnt_t fill_r, fill_nxt;

  logic accept;
  logic full;
  logic [CNT_W:0] app_sum, idx_sum;
  cnt_t app_pos, idx_pos;
  cnt_t pos;
  logic mem_we, mem_re;
  logic idx_in_fill, idx_in_cap;

  logic out_strobe_r, out_read_valid_r, out_evicted_valid_r, out_index_error_r;
  cnt_t out_count_r;

  function automatic cnt_t wrap(input logic [CNT_W:0] s, input cnt_t cap);
    logic [CNT_W:0] d;
    d = s - {1'b0, cap};
    return (s >= {1'b0, cap}) ? d[CNT_W-1:0] : s[CNT_W-1:0];
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (cfg_capacity == '0) begin
      cap_nxt = cnt_t'(1);
    end else if (cfg_capacity > cnt_t'(CAP_MAX)) begin
      cap_nxt = cnt_t'(CAP_MAX);
    end else begin
      cap_nxt = cfg_capacity;
    end
  end

  assign full        = (fill_r >= cap_r);
  assign app_sum     = {1'b0, head_r} + {1'b0, fill_r};
  assign idx_sum     = {1'b0, head_r} + (CNT_W+1)'(in_index);
  assign app_pos     = wrap(app_sum, cap_r);
  assign idx_pos     = wrap(idx_sum, cap_r);
  assign idx_in_fill = (cnt_t'(in_index) < fill_r);
  assign idx_in_cap  = (cnt_t'(in_index) < cap_r);

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    pos      = idx_pos;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (accept) begin
      case (in_operation)
        OP_APPEND: begin
          pos    = app_pos;
          mem_we = 1'b1;
          if (full) begin
            mem_re   = 1'b1;
            head_nxt = wrap({1'b0, head_r} + (CNT_W+1)'(1), cap_r);
          end else begin
            fill_nxt = fill_r + cnt_t'(1);
          end
        end
        OP_READ: begin
          mem_re = idx_in_fill;
        end
        OP_WRITE: begin
          mem_we = idx_in_cap;
        end
        default: begin
          head_nxt = '0;
          fill_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(pos)] <= in_data;
    end
    if (mem_re) begin
      rd_r <= mem[AW'(pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= cnt_t'(CAP_RST);
      head_r <= '0;
      fill_r <= '0;
    end else if (cfg_we) begin
      cap_r  <= cap_nxt;
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r        <= 1'b0;
      out_read_valid_r    <= 1'b0;
      out_evicted_valid_r <= 1'b0;
      out_index_error_r   <= 1'b0;
      out_count_r         <= '0;
    end else begin
      out_strobe_r        <= accept;
      out_read_valid_r    <= accept && (in_operation == OP_READ) && idx_in_fill;
      out_evicted_valid_r <= accept && (in_operation == OP_APPEND) && full;
      out_index_error_r   <= accept && (in_operation == OP_WRITE) && !idx_in_cap;
      out_count_r         <= fill_nxt;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_read_valid    = out_read_valid_r;
  assign out_read_data     = out_read_valid_r ? rd_r : '0;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_data  = out_evicted_valid_r ? rd_r : '0;
  assign out_count         = out_count_r;
  assign out_is_empty      = (out_count_r == '0);
  assign out_index_error   = out_index_error_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_strobe_r == $past(accept)))
    else $error("result strobe does not follow request");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap_r)
    else $error("fill exceeds capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < cap_r)
    else $error("head outside capacity");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_evicted_valid_r |-> ($past(fill_r) == $past(cap_r)))
    else $error("eviction without full buffer");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_read_valid_r && (out_evicted_valid_r || out_index_error_r)))
    else $error("conflicting result flags");

endmodule
